// File: rtl/core/version_range_match_assert.svh
// Assertion macros for the version range matcher.
// Used by version_range_match.sv; needs clk and rst_n in scope.
`ifndef VERSION_RANGE_MATCH_ASSERT_SVH
`define VERSION_RANGE_MATCH_ASSERT_SVH

// check that a condition implies another in the same cycle
`define VRM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that a condition implies another in the next cycle
`define VRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/vrm_pkg.sv
// Package for the version range matcher: parser state types, codes and
// state-update functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrm_pkg;

  localparam int FIELD_WIDTH = 64;

  localparam logic [1:0] VERDICT_UNSAT = 2'd0;
  localparam logic [1:0] VERDICT_SAT   = 2'd1;
  localparam logic [1:0] VERDICT_BAD   = 2'd2;

  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LO_V  = 8'h76;
  localparam logic [7:0] CH_UP_V  = 8'h56;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_START, PH_GT, PH_LT, PH_OPDONE, PH_STAR, PH_FIELD, PH_SUFFIX
  } phase_t;

  typedef enum logic [2:0] {
    OP_EQ, OP_GE, OP_LE, OP_GT, OP_LT, OP_CARET, OP_TILDE
  } op_t;

  typedef struct packed {
    phase_t     phase;
    logic       pbar;
    op_t        op;
    logic [1:0] fidx;
    logic       fdig;
    logic       snon;
    logic       all_true;
    logic       has_tok;
    logic       dec;
    logic [1:0] dval;
  } pstate_t;

  localparam pstate_t PSTATE_RST = '{
    phase: PH_START, pbar: 1'b0, op: OP_EQ, fidx: 2'd0, fdig: 1'b0, snon: 1'b0,
    all_true: 1'b1, has_tok: 1'b0, dec: 1'b0, dval: VERDICT_UNSAT
  };

  function automatic pstate_t fail(input pstate_t s);
    pstate_t r;
    r = s;
    r.dec = 1'b1;
    r.dval = VERDICT_BAD;
    return r;
  endfunction

  function automatic pstate_t tok_end(input pstate_t s, input logic ev);
    pstate_t r;
    logic    res;
    r = s;
    res = 1'b1;
    unique case (s.phase)
      PH_START: return r;
      PH_STAR: res = 1'b1;
      PH_FIELD: begin
        if (s.fidx != 2'd2 || !s.fdig) return fail(r);
        res = ev;
      end
      PH_SUFFIX: begin
        if (!s.snon) return fail(r);
        res = ev;
      end
      default: return fail(r);
    endcase
    r.has_tok = 1'b1;
    r.all_true = s.all_true & res;
    r.phase = PH_START;
    return r;
  endfunction

  function automatic pstate_t clause_end(input pstate_t s, input logic ev);
    pstate_t r;
    r = tok_end(s, ev);
    if (r.dec) return r;
    if (!r.has_tok) return fail(r);
    if (r.all_true) begin
      r.dec = 1'b1;
      r.dval = VERDICT_SAT;
      return r;
    end
    r.has_tok = 1'b0;
    r.all_true = 1'b1;
    r.phase = PH_START;
    return r;
  endfunction

  // a bar not paired with another is legal only inside a suffix
  function automatic pstate_t lone_bar(input pstate_t s);
    pstate_t r;
    r = s;
    if (s.phase == PH_SUFFIX) r.snon = 1'b1;
    else r = fail(s);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/version_range_match.sv
// Version range matcher top level: character parser, evaluation and APB registers.
// Depends on vrm_pkg and version_range_match_assert.svh.
//
// channel   dir  handshake               payload
// in_       in   in_valid / in_stall     in_char_code, in_has_char, in_last
// out_      out  out_valid / out_stall   out_verdict
// apb       in   psel, penable, pready   paddr, pwdata, prdata
//
// One character per cycle; the parser state register holds the whole pass.
// Once the last transaction is registered and the output register is free, the verdict
// is formed from the parser registers and lands there; a new expression may enter then.
// Input stalls only while that verdict waits for a stalled output register.
// Reset is synchronous, active low, and clears the parser state, output valid and APB registers.
`timescale 1ns / 1ps
`default_nettype none
`include "version_range_match_assert.svh"
module version_range_match #(
  parameter int FIELD_WIDTH = vrm_pkg::FIELD_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_has_char,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_verdict,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int FW = FIELD_WIDTH;

  logic [63:0] act_r [3];
  logic [FW-1:0] fld_r [3];
  logic [FW-1:0] fld_nxt [3];
  vrm_pkg::pstate_t st_r, st_nxt, fst;
  logic fin_r, fin_take, in_acc;
  logic out_valid_r;
  logic [1:0] out_verdict_r;
  logic ev;

  // evaluation of the held token against the version under test
  logic [63:0] rq [3];
  logic [63:0] up [3];
  logic [FW-1:0] inc1, inc2, inc0;
  logic lt_req, gt_req, lt_up;

  function automatic logic lt3(input logic [63:0] a0, input logic [63:0] a1,
                               input logic [63:0] a2, input logic [63:0] b0,
                               input logic [63:0] b1, input logic [63:0] b2);
    return (a0 < b0) || (a0 == b0 && (a1 < b1 || (a1 == b1 && a2 < b2)));
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) rq[i] = 64'(fld_r[i]);
    inc0 = fld_r[0] + FW'(1);
    inc1 = fld_r[1] + FW'(1);
    inc2 = fld_r[2] + FW'(1);
    up[0] = 64'd0;
    up[1] = 64'd0;
    up[2] = 64'd0;
    if (st_r.op == vrm_pkg::OP_TILDE) begin
      up[0] = rq[0];
      up[1] = 64'(inc1);
    end else if (fld_r[0] != '0) begin
      up[0] = 64'(inc0);
    end else if (fld_r[1] != '0) begin
      up[1] = 64'(inc1);
    end else begin
      up[2] = 64'(inc2);
    end
    lt_req = lt3(act_r[0], act_r[1], act_r[2], rq[0], rq[1], rq[2]);
    gt_req = lt3(rq[0], rq[1], rq[2], act_r[0], act_r[1], act_r[2]);
    lt_up = lt3(act_r[0], act_r[1], act_r[2], up[0], up[1], up[2]);
    case (st_r.op)
      vrm_pkg::OP_GE: ev = !lt_req;
      vrm_pkg::OP_LE: ev = !gt_req;
      vrm_pkg::OP_GT: ev = gt_req;
      vrm_pkg::OP_LT: ev = lt_req;
      vrm_pkg::OP_CARET, vrm_pkg::OP_TILDE: ev = !lt_req && lt_up;
      default: ev = !lt_req && !gt_req;
    endcase
  end

  assign fin_take = fin_r && (!out_valid_r || !out_stall);
  assign in_stall = fin_r && !fin_take;
  assign in_acc = in_valid && !in_stall;

  // character step
  vrm_pkg::pstate_t s;
  logic [7:0] ch;
  logic plain_go, od, fc, is_sp, is_dig;
  logic [1:0] idx;
  logic [FW+3:0] wide;

  always_comb begin
    s = fin_r ? vrm_pkg::PSTATE_RST : st_r;
    for (int i = 0; i < 3; i++) fld_nxt[i] = fld_r[i];
    ch = in_char_code;
    plain_go = 1'b0;
    od = 1'b0;
    fc = 1'b0;
    idx = 2'd0;
    wide = '0;
    is_sp = (ch == vrm_pkg::CH_SPACE) || (ch >= vrm_pkg::CH_TAB && ch <= vrm_pkg::CH_CR);
    is_dig = (ch >= vrm_pkg::CH_ZERO) && (ch <= vrm_pkg::CH_NINE);
    if (in_has_char && !s.dec) begin
      plain_go = 1'b1;
      if (s.pbar) begin
        s.pbar = 1'b0;
        if (ch == vrm_pkg::CH_BAR) begin
          s = vrm_pkg::clause_end(s, ev);
          plain_go = 1'b0;
        end else begin
          s = vrm_pkg::lone_bar(s);
          if (s.dec) plain_go = 1'b0;
        end
      end
    end
    if (plain_go) begin
      if (ch == vrm_pkg::CH_BAR) begin
        s.pbar = 1'b1;
      end else if (is_sp) begin
        s = vrm_pkg::tok_end(s, ev);
      end else begin
        case (s.phase)
          vrm_pkg::PH_START: begin
            case (ch)
              vrm_pkg::CH_STAR: s.phase = vrm_pkg::PH_STAR;
              vrm_pkg::CH_GT: s.phase = vrm_pkg::PH_GT;
              vrm_pkg::CH_LT: s.phase = vrm_pkg::PH_LT;
              vrm_pkg::CH_EQ: begin
                s.op = vrm_pkg::OP_EQ;
                s.phase = vrm_pkg::PH_OPDONE;
              end
              vrm_pkg::CH_CARET: begin
                s.op = vrm_pkg::OP_CARET;
                s.phase = vrm_pkg::PH_OPDONE;
              end
              vrm_pkg::CH_TILDE: begin
                s.op = vrm_pkg::OP_TILDE;
                s.phase = vrm_pkg::PH_OPDONE;
              end
              default: begin
                s.op = vrm_pkg::OP_EQ;
                od = 1'b1;
              end
            endcase
          end
          vrm_pkg::PH_GT, vrm_pkg::PH_LT: begin
            if (ch == vrm_pkg::CH_EQ) begin
              s.op = (s.phase == vrm_pkg::PH_GT) ? vrm_pkg::OP_GE : vrm_pkg::OP_LE;
              s.phase = vrm_pkg::PH_OPDONE;
            end else begin
              s.op = (s.phase == vrm_pkg::PH_GT) ? vrm_pkg::OP_GT : vrm_pkg::OP_LT;
              od = 1'b1;
            end
          end
          vrm_pkg::PH_OPDONE: od = 1'b1;
          vrm_pkg::PH_FIELD: fc = 1'b1;
          vrm_pkg::PH_SUFFIX: s.snon = 1'b1;
          default: s = vrm_pkg::fail(s);
        endcase
        if (od) begin
          s.phase = vrm_pkg::PH_FIELD;
          s.fidx = 2'd0;
          s.fdig = 1'b0;
          for (int i = 0; i < 3; i++) fld_nxt[i] = '0;
          fc = (ch != vrm_pkg::CH_LO_V) && (ch != vrm_pkg::CH_UP_V);
        end
        if (fc) begin
          idx = (s.fidx == 2'd3) ? 2'd2 : s.fidx;
          wide = {fld_nxt[idx], 3'b000} + {2'b00, fld_nxt[idx], 1'b0}
               + (FW+4)'(ch[3:0]);
          if (is_dig) begin
            if (wide[FW+3:FW] != 4'd0) begin
              s = vrm_pkg::fail(s);
            end else begin
              fld_nxt[idx] = wide[FW-1:0];
              s.fdig = 1'b1;
            end
          end else if (ch == vrm_pkg::CH_DOT) begin
            if (!s.fdig || idx == 2'd2) begin
              s = vrm_pkg::fail(s);
            end else begin
              s.fidx = idx + 2'd1;
              s.fdig = 1'b0;
            end
          end else if (ch == vrm_pkg::CH_MINUS || ch == vrm_pkg::CH_PLUS) begin
            if (idx != 2'd2 || !s.fdig) begin
              s = vrm_pkg::fail(s);
            end else begin
              s.phase = vrm_pkg::PH_SUFFIX;
              s.snon = 1'b0;
            end
          end else begin
            s = vrm_pkg::fail(s);
          end
        end
      end
    end
    st_nxt = s;
  end

  // end of expression, from the held parser state
  always_comb begin
    fst = st_r;
    if (!fst.dec && fst.pbar) begin
      fst.pbar = 1'b0;
      fst = vrm_pkg::lone_bar(fst);
    end
    if (!fst.dec) fst = vrm_pkg::clause_end(fst, ev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vrm_pkg::PSTATE_RST;
      fin_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
        fin_r <= in_last;
      end else if (fin_take) begin
        st_r <= vrm_pkg::PSTATE_RST;
        fin_r <= 1'b0;
      end
      if (fin_take) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) fld_r[i] <= fld_nxt[i];
    end
    if (fin_take) out_verdict_r <= fst.dec ? fst.dval : vrm_pkg::VERDICT_UNSAT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) act_r[i] <= 64'd0;
    end else if (psel && penable && pwrite && paddr[4:3] != 2'd3) begin
      act_r[paddr[4:3]] <= pwdata;
    end
  end

  assign prdata = (paddr[4:3] == 2'd3) ? 64'd0 : act_r[paddr[4:3]];
  assign pready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_verdict = out_verdict_r;

  `VRM_ASSERT_IMPL(a_rose_after_last, $rose(out_valid), $past(fin_r))
  `VRM_ASSERT_IMPL(a_verdict_code, out_valid, out_verdict != 2'd3)
  `VRM_ASSERT_NEXT(a_fin_clears, fin_take && !(in_acc && in_last), !fin_r)

endmodule
`default_nettype wire
